/* src/rgb_channel_shift_wrap_core_defines.svh */
// ---------------------------------------------------------------------------
// rgb_channel_shift_wrap_core_defines
// Assertion macros used by the channel-shift checker file.
// ---------------------------------------------------------------------------
`ifndef RGB_CHANNEL_SHIFT_WRAP_CORE_DEFINES_SVH
`define RGB_CHANNEL_SHIFT_WRAP_CORE_DEFINES_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define RGBSW_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off while rst_n is low
`define RGBSW_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/rgbsw_pkg.sv */
// ---------------------------------------------------------------------------
// rgbsw_pkg
// Types and constants of the RGB channel shift block.
// ---------------------------------------------------------------------------
package rgbsw_pkg;

  localparam int PIX_W  = 8;
  localparam int RW_W   = 11;   // row_width register
  localparam int SH_W   = 11;   // signed shift registers
  localparam int CFG_AW = 5;
  localparam int CFG_DW = 32;

  localparam logic [RW_W-1:0] ROW_WIDTH_RST = 11'd1024;

  localparam logic REQ_PIXEL = 1'b0;
  localparam logic REQ_DRAIN = 1'b1;

  // register word index (byte address / 4)
  typedef enum logic [2:0] {
    REG_ROW_WIDTH   = 3'd0,
    REG_GRAY_MODE   = 3'd1,
    REG_RED_SHIFT   = 3'd2,
    REG_GREEN_SHIFT = 3'd3,
    REG_BLUE_SHIFT  = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic             req_type;
    logic [PIX_W-1:0] in_red;
    logic [PIX_W-1:0] in_green;
    logic [PIX_W-1:0] in_blue;
  } in_item_t;

  typedef struct packed {
    logic [PIX_W-1:0] out_red;
    logic [PIX_W-1:0] out_green;
    logic [PIX_W-1:0] out_blue;
    logic             row_end;
  } out_item_t;

endpackage

/* src/rgb_channel_shift_wrap_core.sv */
// ---------------------------------------------------------------------------
// rgb_channel_shift_wrap_core
// Horizontal per-channel shift with wraparound over a ping-pong row store.
// ---------------------------------------------------------------------------
// A result item passes through the RAM read register and then the output register.
// Throughput: one item per cycle while input is not stalled; the three channel RAM ports set it.
// Each register write starts a remainder unit that reduces the column and the
//   three shifts modulo the row width; input stalls until it is done.
// Reset (rst_n low, synchronous): config to defaults, column, bank and pending
//   row cleared, pipeline empty. Row store contents are not cleared.
module rgb_channel_shift_wrap_core #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // input item channel
  input  logic                           in_valid,
  output logic                           in_stall,
  input  rgbsw_pkg::in_item_t            in_data,
  // result item channel
  output logic                           out_valid,
  input  logic                           out_stall,
  output rgbsw_pkg::out_item_t           out_data,
  // register port
  input  logic                           cfg_psel,
  input  logic                           cfg_penable,
  input  logic                           cfg_pwrite,
  input  logic [rgbsw_pkg::CFG_AW-1:0]   cfg_paddr,
  input  logic [rgbsw_pkg::CFG_DW-1:0]   cfg_pwdata,
  output logic [rgbsw_pkg::CFG_DW-1:0]   cfg_prdata,
  output logic                           cfg_pready
);
  import rgbsw_pkg::*;

  // column index bits, store depth (two banks), remainder unit width
  localparam int CW     = $clog2(MAX_WIDTH);
  localparam int DEPTH  = 2 * MAX_WIDTH;
  localparam int AW     = $clog2(DEPTH);
  localparam int DW     = (CW > SH_W) ? CW : SH_W;
  localparam int SW     = DW + 1;
  localparam int STEP_W = $clog2(DW);
  localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(DW - 1);

  // remainder unit sequence: column first, then the three shifts
  typedef enum logic [4:0] {
    PH_IDLE = 5'b00001,
    PH_COL  = 5'b00010,
    PH_RED  = 5'b00100,
    PH_GRN  = 5'b01000,
    PH_BLU  = 5'b10000
  } red_phase_t;

  // -------------------------------------------------------------------------
  // Register file
  // -------------------------------------------------------------------------
  logic [RW_W-1:0] row_width_r;
  logic            gray_mode_r;
  logic [SH_W-1:0] red_shift_r;
  logic [SH_W-1:0] green_shift_r;
  logic [SH_W-1:0] blue_shift_r;
  logic            cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_width_r   <= ROW_WIDTH_RST;
      gray_mode_r   <= 1'b0;
      red_shift_r   <= '0;
      green_shift_r <= '0;
      blue_shift_r  <= '0;
    end else if (cfg_wr) begin
      case (cfg_reg_t'(cfg_paddr[CFG_AW-1:2]))
        REG_ROW_WIDTH:   row_width_r   <= cfg_pwdata[RW_W-1:0];
        REG_GRAY_MODE:   gray_mode_r   <= cfg_pwdata[0];
        REG_RED_SHIFT:   red_shift_r   <= cfg_pwdata[SH_W-1:0];
        REG_GREEN_SHIFT: green_shift_r <= cfg_pwdata[SH_W-1:0];
        REG_BLUE_SHIFT:  blue_shift_r  <= cfg_pwdata[SH_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg_prdata = '0;
    case (cfg_reg_t'(cfg_paddr[CFG_AW-1:2]))
      REG_ROW_WIDTH:   cfg_prdata = CFG_DW'(row_width_r);
      REG_GRAY_MODE:   cfg_prdata = CFG_DW'(gray_mode_r);
      REG_RED_SHIFT:   cfg_prdata = CFG_DW'(red_shift_r);
      REG_GREEN_SHIFT: cfg_prdata = CFG_DW'(green_shift_r);
      REG_BLUE_SHIFT:  cfg_prdata = CFG_DW'(blue_shift_r);
      default:         cfg_prdata = '0;
    endcase
  end

  // Effective row width: zero acts as one, clamp to the store size.
  logic [RW_W-1:0] w_eff;

  always_comb begin
    if (row_width_r == '0) begin
      w_eff = RW_W'(1);
    end else if (SW'(row_width_r) > SW'(MAX_WIDTH)) begin
      w_eff = RW_W'(MAX_WIDTH);
    end else begin
      w_eff = row_width_r;
    end
  end

  // -------------------------------------------------------------------------
  // Remainder unit: restoring, one dividend bit per cycle, shared by the
  // column and the three shifts. Results: col_x_r = column mod W and
  // *_mod_r = shift mod W in 0..W-1 (negative shifts folded to W - rem).
  // -------------------------------------------------------------------------
  function automatic logic [DW-1:0] shift_mag(input logic [SH_W-1:0] s);
    logic [SH_W-1:0] m;
    m = s[SH_W-1] ? (~s + 1'b1) : s;
    return DW'(m);
  endfunction

  red_phase_t        phase_r, phase_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic [DW-1:0]     dvd_r, dvd_nxt;
  logic [DW-1:0]     rem_r, rem_nxt;
  logic              neg_r, neg_nxt;
  logic [DW:0]       rem_sh;
  logic [DW:0]       w_div;
  logic [DW-1:0]     rem_step;
  logic [RW_W-1:0]   rem_fold;
  logic              step_done;
  logic              busy;

  logic [CW-1:0]     col_r, col_nxt;     // write column
  logic [CW-1:0]     col_x_r, col_x_nxt; // read column (col mod W)
  logic [RW_W-1:0]   red_mod_r, red_mod_nxt;
  logic [RW_W-1:0]   grn_mod_r, grn_mod_nxt;
  logic [RW_W-1:0]   blu_mod_r, blu_mod_nxt;

  assign rem_sh    = {rem_r, dvd_r[DW-1]};
  assign w_div     = (DW+1)'(w_eff);
  assign rem_step  = DW'((rem_sh >= w_div) ? (rem_sh - w_div) : rem_sh);
  assign rem_fold  = (neg_r && (rem_step != '0)) ? (w_eff - RW_W'(rem_step))
                                                 : RW_W'(rem_step);
  assign step_done = (step_r == STEP_LAST);
  assign busy      = (phase_r != PH_IDLE);

  // -------------------------------------------------------------------------
  // Item datapath
  // -------------------------------------------------------------------------
  logic            bank_r, bank_nxt;   // bank being written
  logic            pend_r, pend_nxt;   // a completed row waits in the other bank
  logic            s1_vld_r, s1_vld_nxt;
  logic            s1_end_r, s1_end_nxt;
  logic            out_valid_r;
  out_item_t       out_data_r;

  logic            accept;
  logic            drain;
  logic            do_item;            // accepted item that moves the row state
  logic            produce;            // accepted item that yields a result
  logic            last;
  logic            out_take;
  logic [PIX_W-1:0] wr_red, wr_grn, wr_blu;
  logic [AW-1:0]   wr_addr;
  logic [AW-1:0]   rd_addr_red, rd_addr_grn, rd_addr_blu;
  logic [PIX_W-1:0] rd_red, rd_grn, rd_blu;

  // Read column for one channel: (x - shift) wrapped into 0..W-1.
  function automatic logic [CW-1:0] rd_col(input logic [CW-1:0]   x,
                                           input logic [RW_W-1:0] sm,
                                           input logic [RW_W-1:0] w);
    logic [SW-1:0] d;
    d = SW'(x) - SW'(sm);
    if (d[SW-1]) begin
      d = d + SW'(w);
    end
    return CW'(d);
  endfunction

  // Store address: read bank is the one not being written.
  function automatic logic [AW-1:0] bank_addr(input logic          bank,
                                              input logic [CW-1:0] col);
    return bank ? (AW'(MAX_WIDTH) + AW'(col)) : AW'(col);
  endfunction

  // Output register takes a new item when empty or when its item leaves.
  assign out_take = ~out_valid_r | ~out_stall;

  // Hold input while the remainder unit runs, during a register write, and
  // while the RAM read stage holds an item the output register cannot take.
  assign in_stall = busy | cfg_wr | (s1_vld_r & ~out_take);

  assign accept  = in_valid & ~in_stall;
  assign drain   = (in_data.req_type == REQ_DRAIN);
  // a drain with no pending row is swallowed without effect
  assign do_item = accept & ~(drain & ~pend_r);
  assign produce = accept & pend_r;

  // Last column; also fires when the width shrank below the current column.
  assign last = (SW'(col_r) >= (SW'(w_eff) - SW'(1)));

  // Gray mode copies red into all channels; drains write zero.
  always_comb begin
    wr_red = in_data.in_red;
    wr_grn = gray_mode_r ? in_data.in_red : in_data.in_green;
    wr_blu = gray_mode_r ? in_data.in_red : in_data.in_blue;
    if (drain) begin
      wr_red = '0;
      wr_grn = '0;
      wr_blu = '0;
    end
  end

  assign wr_addr     = bank_addr(bank_r, col_r);
  assign rd_addr_red = bank_addr(~bank_r, rd_col(col_x_r, red_mod_r, w_eff));
  assign rd_addr_grn = bank_addr(~bank_r, rd_col(col_x_r, grn_mod_r, w_eff));
  assign rd_addr_blu = bank_addr(~bank_r, rd_col(col_x_r, blu_mod_r, w_eff));

  // One RAM per channel so all three shifted columns read in the same cycle.
  rgbsw_ram #(.WIDTH(PIX_W), .DEPTH(DEPTH)) u_ram_red (
    .clk     (clk),
    .wr_en   (do_item),
    .wr_addr (wr_addr),
    .wr_data (wr_red),
    .rd_en   (produce),
    .rd_addr (rd_addr_red),
    .rd_data (rd_red)
  );

  rgbsw_ram #(.WIDTH(PIX_W), .DEPTH(DEPTH)) u_ram_grn (
    .clk     (clk),
    .wr_en   (do_item),
    .wr_addr (wr_addr),
    .wr_data (wr_grn),
    .rd_en   (produce),
    .rd_addr (rd_addr_grn),
    .rd_data (rd_grn)
  );

  rgbsw_ram #(.WIDTH(PIX_W), .DEPTH(DEPTH)) u_ram_blu (
    .clk     (clk),
    .wr_en   (do_item),
    .wr_addr (wr_addr),
    .wr_data (wr_blu),
    .rd_en   (produce),
    .rd_addr (rd_addr_blu),
    .rd_data (rd_blu)
  );

  // -------------------------------------------------------------------------
  // Next-state logic: row position and remainder unit
  // -------------------------------------------------------------------------
  always_comb begin
    phase_nxt   = phase_r;
    step_nxt    = step_r + 1'b1;
    dvd_nxt     = dvd_r << 1;
    rem_nxt     = rem_step;
    neg_nxt     = neg_r;
    col_nxt     = col_r;
    col_x_nxt   = col_x_r;
    bank_nxt    = bank_r;
    pend_nxt    = pend_r;
    red_mod_nxt = red_mod_r;
    grn_mod_nxt = grn_mod_r;
    blu_mod_nxt = blu_mod_r;

    if (cfg_wr) begin
      // any register write: restart with the column as dividend
      phase_nxt = PH_COL;
      step_nxt  = '0;
      dvd_nxt   = DW'(col_r);
      rem_nxt   = '0;
      neg_nxt   = 1'b0;
    end else begin
      case (phase_r)
        PH_IDLE: begin
          step_nxt = step_r;
          dvd_nxt  = dvd_r;
          rem_nxt  = rem_r;
        end
        PH_COL: begin
          if (step_done) begin
            col_x_nxt = CW'(rem_step);
            phase_nxt = PH_RED;
            step_nxt  = '0;
            dvd_nxt   = shift_mag(red_shift_r);
            rem_nxt   = '0;
            neg_nxt   = red_shift_r[SH_W-1];
          end
        end
        PH_RED: begin
          if (step_done) begin
            red_mod_nxt = rem_fold;
            phase_nxt   = PH_GRN;
            step_nxt    = '0;
            dvd_nxt     = shift_mag(green_shift_r);
            rem_nxt     = '0;
            neg_nxt     = green_shift_r[SH_W-1];
          end
        end
        PH_GRN: begin
          if (step_done) begin
            grn_mod_nxt = rem_fold;
            phase_nxt   = PH_BLU;
            step_nxt    = '0;
            dvd_nxt     = shift_mag(blue_shift_r);
            rem_nxt     = '0;
            neg_nxt     = blue_shift_r[SH_W-1];
          end
        end
        PH_BLU: begin
          if (step_done) begin
            blu_mod_nxt = rem_fold;
            phase_nxt   = PH_IDLE;
            step_nxt    = '0;
          end
        end
        default: begin
          phase_nxt = PH_IDLE;
          step_nxt  = '0;
        end
      endcase
    end

    // row position; never coincides with a running remainder unit
    if (do_item) begin
      if (last) begin
        col_nxt   = '0;
        col_x_nxt = '0;
        bank_nxt  = ~bank_r;
        pend_nxt  = ~drain;
      end else begin
        col_nxt   = col_r + 1'b1;
        col_x_nxt = col_r + 1'b1;
      end
    end
  end

  // -------------------------------------------------------------------------
  // Next-state logic: RAM read stage and output register
  // -------------------------------------------------------------------------
  always_comb begin
    s1_vld_nxt = s1_vld_r;
    s1_end_nxt = s1_end_r;
    if (produce) begin
      s1_vld_nxt = 1'b1;
      s1_end_nxt = last;
    end else if (out_take) begin
      s1_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      step_r      <= '0;
      neg_r       <= 1'b0;
      col_r       <= '0;
      col_x_r     <= '0;
      bank_r      <= 1'b0;
      pend_r      <= 1'b0;
      red_mod_r   <= '0;
      grn_mod_r   <= '0;
      blu_mod_r   <= '0;
      s1_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      step_r      <= step_nxt;
      neg_r       <= neg_nxt;
      col_r       <= col_nxt;
      col_x_r     <= col_x_nxt;
      bank_r      <= bank_nxt;
      pend_r      <= pend_nxt;
      red_mod_r   <= red_mod_nxt;
      grn_mod_r   <= grn_mod_nxt;
      blu_mod_r   <= blu_mod_nxt;
      s1_vld_r    <= s1_vld_nxt;
      if (out_take) begin
        out_valid_r <= s1_vld_r;
      end
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    dvd_r    <= dvd_nxt;
    rem_r    <= rem_nxt;
    s1_end_r <= s1_end_nxt;
    if (out_take && s1_vld_r) begin
      out_data_r.out_red   <= rd_red;
      out_data_r.out_green <= rd_grn;
      out_data_r.out_blue  <= rd_blu;
      out_data_r.row_end   <= s1_end_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

/* src/rgbsw_ram.sv */
// ---------------------------------------------------------------------------
// rgbsw_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ---------------------------------------------------------------------------
module rgbsw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

/* src/rgbsw_checker.sv */
// ---------------------------------------------------------------------------
// rgbsw_checker
// Port-level assertions for the channel shift block, bound to the top level.
// ---------------------------------------------------------------------------
`include "rgb_channel_shift_wrap_core_defines.svh"

module rgbsw_checker (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_valid,
  input logic                 in_stall,
  input rgbsw_pkg::in_item_t  in_data,
  input logic                 out_valid,
  input logic                 out_stall,
  input rgbsw_pkg::out_item_t out_data,
  input logic                 cfg_psel,
  input logic                 cfg_penable,
  input logic                 cfg_pwrite,
  input logic                 cfg_pready
);
  import rgbsw_pkg::*;

  logic in_acc;
  logic cfg_acc;
  logic acc_d1_r;
  logic acc_d2_r;
  logic drain_seen;

  assign in_acc     = in_valid & ~in_stall;
  assign cfg_acc    = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;
  assign drain_seen = in_acc & (in_data.req_type == REQ_DRAIN);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_d1_r <= 1'b0;
      acc_d2_r <= 1'b0;
    end else begin
      acc_d1_r <= in_acc;
      acc_d2_r <= acc_d1_r;
    end
  end

  // a result item that waits keeps its value
  `RGBSW_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data), "stalled result item changed")

  // a fresh result item follows an accepted item, delayed through acc_d1_r and acc_d2_r
  `RGBSW_ASSERT_SAME(a_out_origin, $rose(out_valid), acc_d2_r, "result item without a source item")

  // register write starts the remainder unit, which holds off input
  `RGBSW_ASSERT_NEXT(a_cfg_stall, cfg_acc, in_stall, "input not held after register write")

  // register writes and accepted items never share an edge
  `RGBSW_ASSERT_SAME(a_cfg_excl, cfg_acc, !in_acc && !drain_seen, "item accepted during write")

endmodule

bind rgb_channel_shift_wrap_core rgbsw_checker u_rgbsw_checker (.*);
